// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the divider.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check outside of reset
`define DIV64_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check at every edge, reset included
`define DIV64_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/div64_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// div64_pkg
// Operation codes and pipeline control type for the 64-bit divider.
// ---------------------------------------------------------------------------
package div64_pkg;

  typedef enum logic [1:0] {
    OP_UDIV = 2'd0,
    OP_UREM = 2'd1,
    OP_SDIV = 2'd2,
    OP_SREM = 2'd3
  } op_t;

  typedef struct packed {
    logic valid;
    logic rem_sel;
    logic neg;
  } ctrl_t;

endpackage
`default_nettype wire

// File: sv/div64_prep.sv
`default_nettype none
// ---------------------------------------------------------------------------
// div64_prep
// Input stage: takes operand magnitudes and records the result sign.
// ---------------------------------------------------------------------------
module div64_prep import div64_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [1:0]       req_type,
  input  wire logic [63:0]      dividend,
  input  wire logic [63:0]      divisor,
  output ctrl_t                 ctl,
  output logic      [WIDTH-1:0] n,
  output logic      [WIDTH-1:0] d
);

  op_t              op;
  logic             is_signed;
  logic             nneg;
  logic             dneg;
  logic [WIDTH-1:0] n_raw;
  logic [WIDTH-1:0] d_raw;
  logic [WIDTH-1:0] n_next;
  logic [WIDTH-1:0] d_next;
  ctrl_t            ctl_next;

  always_comb begin
    op        = op_t'(req_type);
    is_signed = (op == OP_SDIV) || (op == OP_SREM);
    n_raw     = dividend[WIDTH-1:0];
    d_raw     = divisor[WIDTH-1:0];
    nneg      = is_signed && n_raw[WIDTH-1];
    dneg      = is_signed && d_raw[WIDTH-1];
    n_next    = nneg ? (~n_raw + WIDTH'(1)) : n_raw;
    d_next    = dneg ? (~d_raw + WIDTH'(1)) : d_raw;
    ctl_next.valid   = accept;
    ctl_next.rem_sel = (op == OP_UREM) || (op == OP_SREM);
    ctl_next.neg     = ctl_next.rem_sel ? nneg : (nneg ^ dneg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_next;
    end
    n <= n_next;
    d <= d_next;
  end

endmodule
`default_nettype wire

// File: sv/div64_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// div64_cell
// One restoring divide step: shift in a dividend bit, trial subtract.
// ---------------------------------------------------------------------------
module div64_cell import div64_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  ctrl_t                 ctl_in,
  input  wire logic [WIDTH-1:0] r_in,
  input  wire logic [WIDTH-1:0] nq_in,
  input  wire logic [WIDTH-1:0] d_in,
  output ctrl_t                 ctl_out,
  output logic      [WIDTH-1:0] r_out,
  output logic      [WIDTH-1:0] nq_out,
  output logic      [WIDTH-1:0] d_out
);

  logic [WIDTH:0]   shifted;
  logic [WIDTH+1:0] diff;
  logic             borrow;
  logic [WIDTH-1:0] r_next;
  logic [WIDTH-1:0] nq_next;

  always_comb begin
    shifted = {r_in, nq_in[WIDTH-1]};
    diff    = {1'b0, shifted} - {2'b00, d_in};
    borrow  = diff[WIDTH+1];
    r_next  = borrow ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
    nq_next = {nq_in[WIDTH-2:0], ~borrow};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    r_out  <= r_next;
    nq_out <= nq_next;
    d_out  <= d_in;
  end

endmodule
`default_nettype wire

// File: sv/div64_fix.sv
`default_nettype none
// ---------------------------------------------------------------------------
// div64_fix
// Output stage: selects quotient or remainder and applies the sign.
// ---------------------------------------------------------------------------
module div64_fix import div64_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  ctrl_t                 ctl,
  input  wire logic [WIDTH-1:0] q,
  input  wire logic [WIDTH-1:0] r,
  output logic                  done,
  output logic      [63:0]      result
);

  logic [WIDTH-1:0] pick;
  logic [WIDTH-1:0] result_next;

  always_comb begin
    pick        = ctl.rem_sel ? r : q;
    result_next = ctl.neg ? (~pick + WIDTH'(1)) : pick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
    result <= 64'(result_next);
  end

endmodule
`default_nettype wire

// File: sv/divide_64bit_signed_unsigned.sv
`default_nettype none
// ---------------------------------------------------------------------------
// divide_64bit_signed_unsigned
// Pipelined restoring divider: unsigned and signed quotient and remainder.
// ---------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge where start is high and busy is
//   low; req_type selects unsigned quotient, unsigned remainder, signed
//   quotient or signed remainder. Only the low DATA_WIDTH operand bits count.
//   The result appears on result after the input stage, the divide cells and
//   the sign-fix stage, with done high for exactly one cycle; bits above
//   DATA_WIDTH are zero. Throughput is one transaction per cycle while busy
//   is low: an input stage, a chain of DATA_WIDTH divide cells (one quotient
//   bit each) and a sign-fix stage, all registered.
//   busy is high only while rst is high; rst drops all work in flight.
//   There is no result backpressure: done is a strobe and the receiver must
//   take the result in that cycle.
//   Divide by zero gives a quotient of all ones (1 for a signed quotient of a
//   negative dividend) and a remainder equal to the dividend; the most
//   negative value over minus one wraps to itself.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module divide_64bit_signed_unsigned import div64_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic      [63:0] result
);

  localparam int LATENCY = DATA_WIDTH + 2;
  localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;

  ctrl_t                 ctl_s [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] r_s   [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] nq_s  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] d_s   [0:DATA_WIDTH];
  logic                  accept;

  assign busy   = rst;
  assign accept = start && !busy;
  assign r_s[0] = '0;

  div64_prep #(.WIDTH(DATA_WIDTH)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req_type (req_type),
    .dividend (dividend),
    .divisor  (divisor),
    .ctl      (ctl_s[0]),
    .n        (nq_s[0]),
    .d        (d_s[0])
  );

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    div64_cell #(.WIDTH(DATA_WIDTH)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_s[i]),
      .r_in    (r_s[i]),
      .nq_in   (nq_s[i]),
      .d_in    (d_s[i]),
      .ctl_out (ctl_s[i+1]),
      .r_out   (r_s[i+1]),
      .nq_out  (nq_s[i+1]),
      .d_out   (d_s[i+1])
    );
  end

  div64_fix #(.WIDTH(DATA_WIDTH)) u_fix (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl_s[DATA_WIDTH]),
    .q      (nq_s[DATA_WIDTH]),
    .r      (r_s[DATA_WIDTH]),
    .done   (done),
    .result (result)
  );

  `DIV64_ASSERT(a_latency, accept |-> ##LATENCY done, "result strobe missing")
  `DIV64_ASSERT(a_no_spurious, done |-> $past(accept, LATENCY), "result without transaction")
  `DIV64_ASSERT(a_udiv_zero, (accept && (req_type == OP_UDIV) && (divisor[DATA_WIDTH-1:0] == '0)) |-> ##LATENCY (result == 64'(ALL_ONES)), "divide by zero quotient wrong")
  `DIV64_ASSERT_ALWAYS(a_reset_quiet, $past(rst) |-> !done, "strobe after reset")

endmodule
`default_nettype wire
